// ----- rtl/core/der_signature_checker_unit_macros.svh -----
// assertion macros for the strict der signature checker
// no dependencies; included by the top level only
`ifndef DER_SIGNATURE_CHECKER_UNIT_MACROS_SVH
`define DER_SIGNATURE_CHECKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define DERSC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dersc assertion failed");
`define DERSC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dersc assertion failed");
`else
`define DERSC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define DERSC_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/core/dersc_pkg.sv -----
// types and constants for the strict der signature checker
// no dependencies
package dersc_pkg;

    localparam logic [7:0] SEQ_TAG  = 8'h30;
    localparam logic [7:0] INT_TAG  = 8'h02;
    localparam logic [6:0] MAX_LEN  = 7'd72;
    localparam logic [6:0] MIN_LAST = 7'd7;   // position of the last byte of a minimum signature
    localparam logic [6:0] POS_SAT  = 7'd73;

    typedef struct packed {
        logic [7:0] sig_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [6:0] pos;
        logic [7:0] seq_len;
        logic [7:0] r_len;
        logic [7:0] s_len;
        logic       lead_zero;
        logic       violation;
    } track_state_t;

endpackage

// ----- rtl/core/der_signature_checker_unit.sv -----
// strict der signature checker: one signature byte per word, verdict after the last byte
// a verdict passes the input register and then the verdict register before it is offered
// throughput: one byte per cycle; a last byte waits only while the verdict register is full
// reset (aresetn low, synchronous) empties both registers and clears the tracking state
// depends on dersc_pkg, dersc_track and der_signature_checker_unit_macros.svh
`include "der_signature_checker_unit_macros.svh"

module der_signature_checker_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_sig_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_valid_res
);
    import dersc_pkg::*;

    logic  in_valid_reg;
    item_t in_item_reg;
    logic  out_valid_reg;
    logic  out_res_reg;
    logic  out_free;
    logic  in_fire;
    logic  verdict;

    assign out_free = !out_valid_reg || m_ready;
    // a byte that is not last produces nothing, so it never waits on the output side
    assign in_fire  = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign s_ready  = !in_valid_reg || in_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (in_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.sig_byte  <= s_sig_byte;
            in_item_reg.last_byte <= s_last_byte;
        end
    end

    dersc_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (in_fire),
        .item    (in_item_reg),
        .verdict (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire && in_item_reg.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && in_item_reg.last_byte) begin
            out_res_reg <= verdict;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_valid_res = out_res_reg;

    `DERSC_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_ready, in_valid_reg && in_item_reg.last_byte && out_valid_reg && !m_ready)
    `DERSC_ASSERT_NXT(a_last_gives_word, aclk, aresetn, in_fire && in_item_reg.last_byte, m_valid)
    `DERSC_ASSERT_NXT(a_no_word_from_mid, aclk, aresetn, in_fire && !in_item_reg.last_byte && !out_valid_reg, !m_valid)
    `DERSC_ASSERT_NXT(a_no_fire_lost, aclk, aresetn, in_valid_reg && !in_fire, in_valid_reg)

endmodule

// ----- rtl/core/dersc_byte_check.sv -----
// per-word rule checks and the final verdict for one signature byte
// depends on dersc_pkg
module dersc_byte_check (
    input  dersc_pkg::track_state_t cur,
    input  dersc_pkg::item_t        item,
    output dersc_pkg::track_state_t nxt,
    output logic                    verdict
);
    import dersc_pkg::*;

    track_state_t chk;
    logic [8:0]   pw;
    logic [8:0]   lr;
    logic [7:0]   b;
    logic [9:0]   sum_len;

    always_comb begin
        chk = cur;
        pw  = {2'b00, cur.pos};
        lr  = {1'b0, cur.r_len};
        b   = item.sig_byte;
        if (cur.pos < MAX_LEN) begin
            if (cur.pos == 7'd0 && b != SEQ_TAG) chk.violation = 1'b1;
            if (cur.pos == 7'd1) chk.seq_len = b;
            if (cur.pos == 7'd2 && b != INT_TAG) chk.violation = 1'b1;
            if (cur.pos == 7'd3) begin
                chk.r_len = b;
                if (b == 8'd0) chk.violation = 1'b1;
            end
            // first byte of r
            if (cur.pos == 7'd4) begin
                if (b[7]) chk.violation = 1'b1;
                chk.lead_zero = (b == 8'd0);
            end
            if (cur.pos == 7'd5 && cur.r_len > 8'd1 && cur.lead_zero && !b[7])
                chk.violation = 1'b1;
            if (cur.pos >= 7'd4) begin
                if (pw == lr + 9'd4 && b != INT_TAG) chk.violation = 1'b1;
                if (pw == lr + 9'd5) begin
                    chk.s_len = b;
                    if (b == 8'd0) chk.violation = 1'b1;
                end
                // first and second byte of s
                if (pw == lr + 9'd6) begin
                    if (b[7]) chk.violation = 1'b1;
                    chk.lead_zero = (b == 8'd0);
                end else if (pw == lr + 9'd7 && cur.s_len > 8'd1 && cur.lead_zero
                             && !b[7]) begin
                    chk.violation = 1'b1;
                end
            end
        end

        sum_len = 10'd6 + {2'b00, chk.r_len} + {2'b00, chk.s_len};
        verdict = !chk.violation
               && (cur.pos < MAX_LEN)
               && (cur.pos >= MIN_LAST)
               && (chk.seq_len == {1'b0, cur.pos} - 8'd1)
               && ({1'b0, chk.r_len} <= pw - 9'd6)
               && (sum_len == {3'b000, cur.pos} + 10'd1);

        if (item.last_byte) begin
            nxt = '0;
        end else begin
            nxt = chk;
            if (cur.pos < POS_SAT) nxt.pos = cur.pos + 7'd1;
        end
    end

endmodule

// ----- rtl/core/dersc_track.sv -----
// per-signature tracking state: position, length fields and flags
// depends on dersc_pkg and dersc_byte_check
module dersc_track (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  dersc_pkg::item_t item,
    output logic             verdict
);
    import dersc_pkg::*;

    track_state_t state_reg;
    track_state_t state_next;

    dersc_byte_check u_check (
        .cur     (state_reg),
        .item    (item),
        .nxt     (state_next),
        .verdict (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

endmodule
